[src/binary_tree_sorter_descending_macros.svh]
// Assertion macros for the binary tree sorter.
// Used by binary_tree_sorter_descending.sv; expects clk and rst_n in scope.
`ifndef BINARY_TREE_SORTER_DESCENDING_MACROS_SVH
`define BINARY_TREE_SORTER_DESCENDING_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bts_pkg.sv]
// Shared types for the binary tree sorter.
// No dependencies; used by the channel interfaces and the top level.
package bts_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

[src/bts_in_if.sv]
// Input channel of the binary tree sorter: valid/ready plus one sample item.
// Depends on bts_pkg.
interface bts_in_if
    import bts_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t sample_value;
    logic   run_end;

    modport source (output valid, output sample_value, output run_end, input ready);
    modport sink   (input valid, input sample_value, input run_end, output ready);
endinterface

[src/bts_out_if.sv]
// Output channel of the binary tree sorter: valid/ready plus one sorted item.
// Depends on bts_pkg.
interface bts_out_if
    import bts_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   final_result;
    logic   overflowed;

    modport source (output valid, output sorted_value, output final_result,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input final_result,
                    input overflowed, output ready);
endinterface

[src/binary_tree_sorter_descending.sv]
// Insert: S_IDLE accepts the item; unless it is the root, S_INS_CMP then
// descends level by level, paced by the registered node memory read, until
// it writes a free link; no new item is taken before that. Read-out: S_W_START
// sets up; S_W_EVAL goes right, emits unless stalled, goes left; S_W_POP pops.
// Reset (rst_n, async, active low) empties the tree and clears the overflow
// flag; the node and stack memories are not cleared.
module binary_tree_sorter_descending
    import bts_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    bts_in_if.sink    samples,
    bts_out_if.source results
);

`include "binary_tree_sorter_descending_macros.svh"

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ITEMS);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_W_START,
        S_W_EVAL,
        S_W_POP
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   overflow_reg, overflow_next;
    idx_t   slot_reg, slot_next;
    value_t value_reg, value_next;
    logic   last_reg, last_next;
    idx_t   loc_reg, loc_next;
    idx_t   sp_reg, sp_next;
    cnt_t   n_reg, n_next;
    logic   popped_reg, popped_next;
    logic   out_valid_reg, out_valid_next;
    value_t out_value_reg, out_value_next;
    logic   out_final_reg, out_final_next;
    logic   out_ovf_reg, out_ovf_next;

    // Node and path stack memories, read data registered.
    value_t value_mem [MAX_ITEMS];
    idx_t   left_mem  [MAX_ITEMS];
    idx_t   right_mem [MAX_ITEMS];
    idx_t   stack_mem [MAX_ITEMS];
    value_t node_val_reg;
    idx_t   node_left_reg;
    idx_t   node_right_reg;
    idx_t   stack_top_reg;

    idx_t   node_raddr;
    logic   val_we;
    idx_t   val_waddr;
    logic   left_we;
    idx_t   left_waddr;
    idx_t   left_wdata;
    logic   right_we;
    idx_t   right_waddr;
    idx_t   right_wdata;
    logic   stack_we;

    logic   accept;
    logic   out_free;
    logic   greater;
    logic   final_hit;
    logic   emit;
    idx_t   right_eff;
    idx_t   new_slot;

    assign accept    = samples.valid && samples.ready;
    assign out_free  = !out_valid_reg || results.ready;
    assign greater   = value_reg > node_val_reg;
    assign final_hit = (n_reg + CNT_W'(1)) == count_reg;
    assign new_slot  = count_reg[IDX_W-1:0];
    // A node reached by a pop has its right subtree done.
    assign right_eff = popped_reg ? '0 : node_right_reg;
    assign emit      = (state_reg == S_W_EVAL) && (right_eff == '0) && out_free;

    assign samples.ready        = (state_reg == S_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.final_result = out_final_reg;
    assign results.overflowed   = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        loc_next       = loc_reg;
        sp_next        = sp_reg;
        n_next         = n_reg;
        popped_next    = popped_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        out_ovf_next   = out_ovf_reg;

        node_raddr  = loc_reg;
        val_we      = 1'b0;
        val_waddr   = new_slot;
        left_we     = 1'b0;
        left_waddr  = loc_reg;
        left_wdata  = '0;
        right_we    = 1'b0;
        right_waddr = loc_reg;
        right_wdata = '0;
        stack_we    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = samples.sample_value;
                    last_next  = samples.run_end;
                    if (count_reg != FULL_COUNT)
                    begin
                        // Allocate the node with empty links, start at the root.
                        val_we      = 1'b1;
                        left_we     = 1'b1;
                        left_waddr  = new_slot;
                        right_we    = 1'b1;
                        right_waddr = new_slot;
                        count_next  = count_reg + CNT_W'(1);
                        slot_next   = new_slot;
                        loc_next    = '0;
                        node_raddr  = '0;
                        if (new_slot != '0)
                            state_next = S_INS_CMP;
                        else if (samples.run_end)
                            state_next = S_W_START;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                        if (samples.run_end)
                            state_next = S_W_START;
                    end
                end
            end

            S_INS_CMP:
            begin
                if (greater)
                begin
                    if (node_right_reg != '0)
                    begin
                        loc_next   = node_right_reg;
                        node_raddr = node_right_reg;
                    end
                    else
                    begin
                        right_we    = 1'b1;
                        right_wdata = slot_reg;
                        state_next  = last_reg ? S_W_START : S_IDLE;
                    end
                end
                else
                begin
                    if (node_left_reg != '0)
                    begin
                        loc_next   = node_left_reg;
                        node_raddr = node_left_reg;
                    end
                    else
                    begin
                        left_we    = 1'b1;
                        left_wdata = slot_reg;
                        state_next = last_reg ? S_W_START : S_IDLE;
                    end
                end
            end

            S_W_START:
            begin
                // Separate cycle so the root read sees the last link write.
                loc_next    = '0;
                node_raddr  = '0;
                sp_next     = '0;
                n_next      = '0;
                popped_next = 1'b0;
                state_next  = S_W_EVAL;
            end

            S_W_EVAL:
            begin
                if (right_eff != '0)
                begin
                    stack_we    = 1'b1;
                    sp_next     = sp_reg + IDX_W'(1);
                    loc_next    = right_eff;
                    node_raddr  = right_eff;
                    popped_next = 1'b0;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = node_val_reg;
                    out_final_next = final_hit;
                    out_ovf_next   = overflow_reg;
                    n_next         = n_reg + CNT_W'(1);
                    if (final_hit || (node_left_reg == '0 && sp_reg == '0))
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                    else if (node_left_reg != '0)
                    begin
                        loc_next    = node_left_reg;
                        node_raddr  = node_left_reg;
                        popped_next = 1'b0;
                    end
                    else
                    begin
                        // Stack read of entry sp-1 lands this edge.
                        sp_next    = sp_reg - IDX_W'(1);
                        state_next = S_W_POP;
                    end
                end
            end

            S_W_POP:
            begin
                loc_next    = stack_top_reg;
                node_raddr  = stack_top_reg;
                right_we    = 1'b1;
                right_waddr = stack_top_reg;
                right_wdata = '0;
                popped_next = 1'b1;
                state_next  = S_W_EVAL;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            slot_reg      <= '0;
            value_reg     <= '0;
            last_reg      <= 1'b0;
            loc_reg       <= '0;
            sp_reg        <= '0;
            n_reg         <= '0;
            popped_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_final_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            slot_reg      <= slot_next;
            value_reg     <= value_next;
            last_reg      <= last_next;
            loc_reg       <= loc_next;
            sp_reg        <= sp_next;
            n_reg         <= n_next;
            popped_reg    <= popped_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_final_reg <= out_final_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            value_mem[val_waddr] <= value_next;
        if (left_we)
            left_mem[left_waddr] <= left_wdata;
        if (right_we)
            right_mem[right_waddr] <= right_wdata;
        if (stack_we)
            stack_mem[sp_reg] <= loc_reg;
        node_val_reg   <= value_mem[node_raddr];
        node_left_reg  <= left_mem[node_raddr];
        node_right_reg <= right_mem[node_raddr];
        stack_top_reg  <= stack_mem[sp_reg - IDX_W'(1)];
    end

    `BTS_ASSERT_NEXT(a_full_sets_overflow, accept && (count_reg == FULL_COUNT), overflow_reg, "dropped item did not set overflow")

    `BTS_ASSERT_NOW(a_walk_within_count, state_reg == S_W_EVAL, n_reg < count_reg, "read-out ran past stored count")

    `BTS_ASSERT_NOW(a_descent_not_root, state_reg == S_INS_CMP, slot_reg != '0, "descent started for the root node")

    `BTS_ASSERT_NEXT(a_final_clears, emit && final_hit, (count_reg == '0) && !overflow_reg && (state_reg == S_IDLE), "tree not cleared after last item")

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench for binary_tree_sorter_descending: feeds runs of signed values and
// checks every read-out item against a scoreboard that keeps each run sorted.
// Depends on bts_pkg, bts_in_if, bts_out_if and the sorter top level.

typedef struct packed {
    bts_pkg::value_t value;
    logic            last_flag;
    logic            dropped_flag;
} sorted_item_t;

class sort_scoreboard;
    int              capacity;
    bts_pkg::value_t held_values[$];    // current run, largest first
    bit              values_dropped;
    sorted_item_t    awaited[$];
    int              mismatches;
    int              samples_seen;
    int              results_seen;
    int              runs_done;
    int              overflow_runs;

    function new(int capacity_n);
        capacity = capacity_n;
    endfunction

    function void note_sample(bts_pkg::value_t v, logic last);
        int           pos;
        sorted_item_t exp_item;
        samples_seen++;
        if (held_values.size() < capacity) begin
            pos = 0;
            // equal values are bit-identical, so their order among themselves is moot
            while (pos < held_values.size() && held_values[pos] >= v)
                pos++;
            held_values.insert(pos, v);
        end
        else
            values_dropped = 1'b1;
        if (last) begin
            // a dropped last item still starts the read-out
            foreach (held_values[i]) begin
                exp_item.value        = held_values[i];
                exp_item.last_flag    = (i == held_values.size() - 1);
                exp_item.dropped_flag = values_dropped;
                awaited.push_back(exp_item);
            end
            runs_done++;
            if (values_dropped)
                overflow_runs++;
            held_values.delete();
            values_dropped = 1'b0;
        end
    endfunction

    function void check_result(bts_pkg::value_t v, logic last, logic dropped);
        sorted_item_t exp_item;
        results_seen++;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR @%0t: unexpected item value %0d final %0b overflow %0b",
                         $time, v, last, dropped);
            return;
        end
        exp_item = awaited.pop_front();
        if (v !== exp_item.value || last !== exp_item.last_flag ||
            dropped !== exp_item.dropped_flag) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR @%0t: item %0d expected %0d/%0b/%0b, got %0d/%0b/%0b",
                         $time, results_seen, exp_item.value, exp_item.last_flag,
                         exp_item.dropped_flag, v, last, dropped);
        end
    endfunction
endclass

module tb;
    import bts_pkg::*;

    localparam int     CAPACITY      = 64;
    localparam int     TOTAL_ITEMS   = 120;
    localparam int     QUIET_AFTER   = 95;
    localparam int     STALL_LIMIT   = 2000;
    localparam int     DRAIN_CYCLES  = 250;
    localparam value_t VALUE_MIN     = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam value_t VALUE_MAX     = {1'b0, {(VALUE_W-1){1'b1}}};

    localparam int PAT_RANDOM     = 0;
    localparam int PAT_NARROW     = 1;
    localparam int PAT_ASCENDING  = 2;
    localparam int PAT_DESCENDING = 3;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   stall_left;
    int   idle_cycles;
    int   sent_items;

    sort_scoreboard sb = new(CAPACITY);

    bts_in_if  sample_ch();
    bts_out_if result_ch();

    binary_tree_sorter_descending #(.MAX_ITEMS(CAPACITY)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sink side: random stall bursts until the quiet tail of the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            result_ch.ready <= (stall_left == 0);
            if (stall_left != 0)
                stall_left = stall_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample(sample_ch.sample_value, sample_ch.run_end);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.sorted_value, result_ch.final_result,
                                result_ch.overflowed);
            if ((sample_ch.valid && sample_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR @%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("binary_tree_sorter_descending test failed");
                $finish;
            end
        end
    end

    // Hold valid high across back-to-back items; drop it only for a gap.
    task automatic send_sample(input value_t v, input logic last);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= v;
        sample_ch.run_end      <= last;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        sent_items++;
    endtask

    initial
    begin
        int     run_no;
        int     run_len;
        int     pattern;
        int     step;
        value_t base;
        value_t v;

        idle_cycles             = 0;
        sent_items              = 0;
        quiet                   = 1'b0;
        rst_n                  <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        sample_ch.run_end      <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-value runs at both extremes
        send_sample(VALUE_MIN, 1'b1);
        send_sample(VALUE_MAX, 1'b1);
        // mixed signs around zero plus both extremes
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(VALUE_MAX, 1'b0);
        send_sample(VALUE_MIN, 1'b0);
        send_sample(7, 1'b1);
        // equal values must come out side by side
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(-3, 1'b0);
        send_sample(5, 1'b0);
        send_sample(-3, 1'b1);
        // rising order builds a right-leaning chain, falling order a left one
        send_sample(1, 1'b0);
        send_sample(2, 1'b0);
        send_sample(3, 1'b0);
        send_sample(4, 1'b1);
        send_sample(4, 1'b0);
        send_sample(3, 1'b0);
        send_sample(2, 1'b0);
        send_sample(1, 1'b1);

        run_no = 0;
        while (sent_items < TOTAL_ITEMS)
        begin
            case (run_no)
                // rising chain one past capacity: the last item itself is dropped
                1: begin run_len = CAPACITY + 1; pattern = PAT_ASCENDING; end
                default:
                begin
                    run_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
                    pattern = $urandom_range(PAT_RANDOM, PAT_DESCENDING);
                end
            endcase
            base = $urandom;
            base = base >>> 2;
            step = $urandom_range(1, 3);
            for (int k = 0; k < run_len; k++)
            begin
                case (pattern)
                    PAT_RANDOM:    v = $urandom;
                    PAT_NARROW:    v = $urandom_range(0, 8) - 4;
                    PAT_ASCENDING: v = base + k * step;
                    default:       v = base - k * step;
                endcase
                if (pattern == PAT_RANDOM && $urandom_range(0, 15) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       v = VALUE_MIN;
                        1:       v = VALUE_MAX;
                        2:       v = 0;
                        default: v = -1;
                    endcase
                end
                send_sample(v, k == run_len - 1);
            end
            if (sent_items >= QUIET_AFTER)
                quiet = 1'b1;
            run_no++;
        end
        sample_ch.valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d runs (%0d past capacity) from %0d input items.",
                 sb.runs_done, sb.overflow_runs, sb.samples_seen);
        $display("Checked %0d sorted items, %0d mismatches.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("binary_tree_sorter_descending test passed");
        else
            $display("binary_tree_sorter_descending test failed");
        $finish;
    end

endmodule
